FILE: hdl/pqfs_pkg.sv
// Shared types and constants for the prime quadratic form split block.
`timescale 1ns / 1ps

package pqfs_pkg;

    // Fixed field widths of the stream payload and configuration port.
    localparam int PRIME_IN_W  = 32;
    localparam int A_W         = 19;
    localparam int B_W         = 18;
    localparam int D_W         = 8;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    // d * (2b - 1) with an 8-bit d and b below 2^18 fits in 27 bits.
    localparam int DEC_W = D_W + B_W + 1;

    localparam logic [B_W-1:0] B_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FIELD_D   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORM_MODE = 1'b1;

    localparam logic [D_W-1:0] FIELD_D_RESET   = 8'd1;
    localparam logic           FORM_MODE_RESET = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_ROOT,
        ST_TEST,
        ST_DONE
    } pqfs_state_t;

    typedef struct packed {
        logic                  found;
        logic signed [A_W-1:0] coef_a;
        logic [B_W-1:0]        coef_b;
    } pqfs_result_t;

endpackage

FILE: hdl/pqfs_alu.sv
// Shared subtract and compare unit used by every search and root step.
`timescale 1ns / 1ps

module pqfs_alu #(
    parameter int W = 34
) (
    input  logic [W-1:0] op_x,
    input  logic [W-1:0] op_y,
    output logic [W-1:0] diff,
    output logic         borrow
);

    // Borrow is set when op_y is larger than op_x.
    assign {borrow, diff} = {1'b0, op_x} - {1'b0, op_y};

endmodule

FILE: hdl/pqfs_core.sv
// Search sequencer and datapath: running remainder, digit-serial square root.
`timescale 1ns / 1ps

module pqfs_core #(
    parameter int PRIME_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [pqfs_pkg::PRIME_IN_W-1:0]   prime_value,
    input  logic [pqfs_pkg::D_W-1:0]          field_d,
    input  logic                              form_mode,
    output logic                              idle,
    output logic                              done,
    input  logic                              take,
    output pqfs_pkg::pqfs_result_t            result
);

    import pqfs_pkg::*;

    localparam int IN_W     = (PRIME_BITS < PRIME_IN_W) ? PRIME_BITS : PRIME_IN_W;
    localparam int REM_W    = PRIME_BITS + 2;
    localparam int SQ_STEPS = (REM_W + 1) / 2;
    localparam int RES_W    = SQ_STEPS;
    localparam int TOP_POS  = 2 * (SQ_STEPS - 1);
    localparam int CNT_W    = $clog2(SQ_STEPS);
    localparam int ALU_W    = (REM_W > DEC_W) ? REM_W : DEC_W;
    localparam int DW       = ((RES_W > B_W) ? RES_W : B_W) + 2;

    localparam logic [REM_W-1:0] TOP_BIT  = REM_W'(1) << TOP_POS;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SQ_STEPS - 1);

    pqfs_state_t state_reg, state_next;

    logic [REM_W-1:0] rem_reg, rem_next;
    logic [REM_W-1:0] v_reg, v_next;
    logic [REM_W-1:0] res_reg, res_next;
    logic [REM_W-1:0] bit_reg, bit_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [B_W-1:0]   b_reg, b_next;
    logic [DEC_W-1:0] dec_reg, dec_next;
    logic             found_reg, found_next;
    logic [A_W-1:0]   a_reg, a_next;

    logic [ALU_W-1:0] alu_x, alu_y, alu_diff;
    logic             alu_borrow;
    logic [REM_W-1:0] p_ext;
    logic [REM_W-1:0] trial;
    logic             is_square;
    logic             at_limit;

    logic signed [DW-1:0] diff_s, sum_s, half_s;
    logic [A_W-1:0]       a_hit;

    pqfs_alu #(
        .W(ALU_W)
    ) u_alu (
        .op_x  (alu_x),
        .op_y  (alu_y),
        .diff  (alu_diff),
        .borrow(alu_borrow)
    );

    assign p_ext     = REM_W'(prime_value[IN_W-1:0]);
    assign trial     = res_reg | bit_reg;
    assign is_square = (v_reg == '0);
    assign at_limit  = (b_reg == B_MAX);

    // Half-integral coordinate: (sqrt - b) / 2, truncated toward zero.
    assign diff_s = signed'(DW'(res_reg[RES_W-1:0]) - DW'(b_reg));
    assign sum_s  = diff_s + signed'(DW'(diff_s[DW-1]));
    assign half_s = sum_s >>> 1;
    assign a_hit  = form_mode ? half_s[A_W-1:0] : A_W'(DW'(res_reg[RES_W-1:0]));

    always_comb begin
        alu_x = '0;
        alu_y = '0;
        case (state_reg)
            ST_STEP: begin
                alu_x = ALU_W'(rem_reg);
                alu_y = ALU_W'(dec_reg);
            end
            ST_ROOT: begin
                alu_x = ALU_W'(v_reg);
                alu_y = ALU_W'(trial);
            end
            default: begin
                alu_x = '0;
                alu_y = '0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (start) state_next = ST_STEP;
            ST_STEP: state_next = alu_borrow ? ST_DONE : ST_ROOT;
            ST_ROOT: if (cnt_reg == '0) state_next = ST_TEST;
            ST_TEST: if (is_square || at_limit) state_next = ST_DONE;
                     else state_next = ST_STEP;
            ST_DONE: if (take) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath updates.
    always_comb begin
        rem_next   = rem_reg;
        v_next     = v_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        cnt_next   = cnt_reg;
        b_next     = b_reg;
        dec_next   = dec_reg;
        found_next = found_reg;
        a_next     = a_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    rem_next   = form_mode ? {p_ext[REM_W-3:0], 2'b00} : p_ext;
                    b_next     = B_W'(1);
                    dec_next   = DEC_W'(field_d);
                    found_next = 1'b0;
                    a_next     = '0;
                end
            end
            ST_STEP: begin
                if (alu_borrow) begin
                    found_next = 1'b0;
                    a_next     = '0;
                end else begin
                    rem_next = alu_diff[REM_W-1:0];
                    v_next   = alu_diff[REM_W-1:0];
                    res_next = '0;
                    bit_next = TOP_BIT;
                    cnt_next = CNT_LAST;
                end
            end
            ST_ROOT: begin
                if (!alu_borrow) begin
                    v_next   = alu_diff[REM_W-1:0];
                    res_next = (res_reg >> 1) | bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg - CNT_W'(1);
            end
            ST_TEST: begin
                if (is_square) begin
                    found_next = 1'b1;
                    a_next     = a_hit;
                end else if (at_limit) begin
                    found_next = 1'b0;
                    a_next     = '0;
                end else begin
                    b_next   = b_reg + B_W'(1);
                    dec_next = dec_reg + DEC_W'({field_d, 1'b0});
                end
            end
            default: begin
                found_next = found_reg;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk) begin
        rem_reg   <= rem_next;
        v_reg     <= v_next;
        res_reg   <= res_next;
        bit_reg   <= bit_next;
        cnt_reg   <= cnt_next;
        b_reg     <= b_next;
        dec_reg   <= dec_next;
        found_reg <= found_next;
        a_reg     <= a_next;
    end

    assign idle          = (state_reg == ST_IDLE);
    assign done          = (state_reg == ST_DONE);
    assign result.found  = found_reg;
    assign result.coef_a = signed'(a_reg);
    assign result.coef_b = found_reg ? b_reg : '0;

endmodule

FILE: hdl/prime_quadratic_form_split.sv
// Top level: configuration registers, input stream, search core, output register.
`timescale 1ns / 1ps

// Writes a prime p as a^2 + d*b^2 (form_mode 0) or, with 4p, as a norm with a
// half-integral coordinate (form_mode 1), taking the smallest b >= 1 for which
// the remainder is a perfect square.
//
// Channels: one input beat on s_ carries p; one output beat on m_ carries a
// and b in m_tdata and the found flag in m_tuser. Configuration is a plain
// write port (index 0 = field_d, index 1 = form_mode), written while idle.
//
// Search: each tried b takes one remainder step, (PRIME_BITS + 3) / 2 square
// root steps and one test step; the remainder and root steps share the single
// subtractor. The worst case tries 2^18 - 1 values of b. s_tready is high only
// while the search core is idle, so the next input beat waits until the core
// has passed its result on to the output register.
//
// Reset clears the sequencer and the output valid and loads field_d = 1 and
// form_mode = 0. When the receiver stalls, the result waits in the output
// register while the core can accept and work on the next prime; a second
// finished result then waits in the core until the output register frees.
module prime_quadratic_form_split #(
    parameter int PRIME_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [31:0] prime_value
    input  logic [pqfs_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [18:0] coef_a, [36:19] coef_b, [39:37] zero
    output logic [pqfs_pkg::M_TDATA_W-1:0]     m_tdata,
    // [0] found_flag
    output logic                               m_tuser,
    input  logic                               cfg_wr_en,
    input  logic [pqfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pqfs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    import pqfs_pkg::*;

    logic [D_W-1:0] field_d_reg;
    logic           form_mode_reg;

    logic           core_idle;
    logic           core_done;
    logic           core_take;
    logic           in_beat;
    pqfs_result_t   core_result;

    logic           m_valid_reg, m_valid_next;
    pqfs_result_t   m_data_reg;

    // Config regs: writes must arrive only while the block is idle; not enforced.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_d_reg   <= FIELD_D_RESET;
            form_mode_reg <= FORM_MODE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FIELD_D:   field_d_reg   <= cfg_wdata[D_W-1:0];
                CFG_FORM_MODE: form_mode_reg <= cfg_wdata[0];
                default:       field_d_reg   <= field_d_reg;
            endcase
        end
    end

    assign s_tready = core_idle;
    assign in_beat  = s_tvalid && core_idle;

    pqfs_core #(
        .PRIME_BITS(PRIME_BITS)
    ) u_core (
        .clk        (aclk),
        .rst_n      (aresetn),
        .start      (in_beat),
        .prime_value(s_tdata[PRIME_IN_W-1:0]),
        .field_d    (field_d_reg),
        .form_mode  (form_mode_reg),
        .idle       (core_idle),
        .done       (core_done),
        .take       (core_take),
        .result     (core_result)
    );

    // The output register takes a finished result whenever it is empty or
    // its current beat leaves in the same cycle.
    assign core_take = core_done && (!m_valid_reg || m_tready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (core_take) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_take) begin
            m_data_reg <= core_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - A_W - B_W)'(0), m_data_reg.coef_b, m_data_reg.coef_a};
    assign m_tuser  = m_data_reg.found;

endmodule

FILE: hdl/pqfs_chk.sv
// Port-level assertion checker for the prime quadratic form split block.
`timescale 1ns / 1ps

module pqfs_chk (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [pqfs_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                               m_tuser
);

    import pqfs_pkg::*;

    // One prime at a time: an accepted beat closes the input until done.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input stayed open after an accepted beat");

    // A not-found result carries zero coordinates.
    a_miss_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("not-found result with nonzero coordinates");

    // A found result always has b of at least one.
    a_hit_b_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[A_W+B_W-1:A_W] != '0))
        else $error("found result with b equal to zero");

    // No result is pending right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // A stalled output beat holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("output beat changed while stalled");

endmodule

bind prime_quadratic_form_split pqfs_chk u_pqfs_chk (.*);

FILE: bench/pqfs_split_checker.sv
// Scoreboard for the prime quadratic form split block: predicts each split and checks output beats.
`timescale 1ns / 1ps

module pqfs_split_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [pqfs_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [pqfs_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             m_tuser,
    input  logic                             cfg_wr_en,
    input  logic [pqfs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pqfs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                               fail_count,
    output int                               pending_count,
    output int                               found_count,
    output int                               miss_count
);

    import pqfs_pkg::*;

    // Shadow copies of the two configuration registers.
    logic [D_W-1:0] shadow_d    = FIELD_D_RESET;
    logic           shadow_mode = FORM_MODE_RESET;

    pqfs_result_t   expected_splits[$];
    pqfs_result_t   want;
    logic signed [A_W-1:0]     got_a;
    logic [B_W-1:0]            got_b;
    logic [M_TDATA_W-A_W-B_W-1:0] got_pad;
    logic           got_found;
    logic           beat_bad;
    int             errors = 0;
    int             hits   = 0;
    int             misses = 0;

    // Largest x with x*x <= v; remainders stay below 2^34, so 2^17 bounds the root.
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd131072;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // Expected result for prime p under the given field_d and form_mode.
    function automatic pqfs_result_t split_prime(input logic [PRIME_IN_W-1:0] p,
                                                 input logic [D_W-1:0] d,
                                                 input logic mode);
        longint unsigned rem;
        longint unsigned dec;
        longint unsigned root;
        longint unsigned b;
        longint unsigned dval;
        longint          half;
        bit              hit;
        pqfs_result_t    r;
        dval = 64'(d);
        rem  = mode ? (longint'(p) << 2) : longint'(p);
        root = 0;
        hit  = 1'b0;
        for (b = 1; b <= B_MAX; b++) begin
            dec = dval * (2 * b - 1);
            if (dec > rem) break;
            rem  = rem - dec;
            root = floor_root(rem);
            if (root * root == rem) begin
                hit = 1'b1;
                break;
            end
        end
        r = '0;
        if (hit) begin
            if (mode) begin
                // Integer division truncates toward zero, as the halving must.
                half = (longint'(root) - longint'(b)) / 2;
                r.coef_a = half[A_W-1:0];
            end else begin
                r.coef_a = root[A_W-1:0];
            end
            r.coef_b = b[B_W-1:0];
            r.found  = 1'b1;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            shadow_d    = FIELD_D_RESET;
            shadow_mode = FORM_MODE_RESET;
            expected_splits.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FIELD_D:   shadow_d    = cfg_wdata;
                    CFG_FORM_MODE: shadow_mode = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_splits.push_back(split_prime(s_tdata, shadow_d, shadow_mode));
            end
            if (m_tvalid && m_tready) begin
                got_a     = m_tdata[A_W-1:0];
                got_b     = m_tdata[A_W+B_W-1:A_W];
                got_pad   = m_tdata[M_TDATA_W-1:A_W+B_W];
                got_found = m_tuser;
                if (expected_splits.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got a=%0d b=%0d f=%0b",
                             $time, got_a, got_b, got_found);
                    errors++;
                end else begin
                    want     = expected_splits.pop_front();
                    beat_bad = 1'b0;
                    if (got_a !== want.coef_a) begin
                        $display("%0t: coef_a mismatch, expected %0d, got %0d",
                                 $time, want.coef_a, got_a);
                        beat_bad = 1'b1;
                    end
                    if (got_b !== want.coef_b) begin
                        $display("%0t: coef_b mismatch, expected %0d, got %0d",
                                 $time, want.coef_b, got_b);
                        beat_bad = 1'b1;
                    end
                    if (got_found !== want.found) begin
                        $display("%0t: found_flag mismatch, expected %0b, got %0b",
                                 $time, want.found, got_found);
                        beat_bad = 1'b1;
                    end
                    if (got_pad !== '0) begin
                        $display("%0t: m_tdata padding mismatch, expected 0, got %0h",
                                 $time, got_pad);
                        beat_bad = 1'b1;
                    end
                    if (beat_bad) errors++;
                    if (want.found) begin
                        hits++;
                    end else begin
                        misses++;
                    end
                end
            end
        end
        pending_count <= expected_splits.size();
        fail_count    <= errors;
        found_count   <= hits;
        miss_count    <= misses;
    end

endmodule

FILE: bench/tb_prime_quadratic_form_split.sv
// Testbench top for the prime quadratic form split block: stimulus, flow control and verdict.
`timescale 1ns / 1ps

// The top drives primes into the s_ channel and the configuration port, and
// throttles the m_ channel. All prediction and comparison live in the checker,
// which watches the same wires and reports its failure count back here.
//
// A search grows longer with every tried b, so the primes are chosen to
// keep searches short: small values, whose search runs out quickly, and large
// values built as d + k*k, which hit at b = 1 or b = 2. A field_d of 0 makes
// the remainder constant, so with it only perfect squares are sent; anything
// else would run the search out to the coef_b bound.
module tb_prime_quadratic_form_split;

    import pqfs_pkg::*;

    // The slowest plausible run is about 100 items, each searching at most ~180
    // values of b, plus the longest gaps and stalls; CYCLE_LIMIT must cover it.
    localparam int CYCLE_LIMIT    = 4000000;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int TAIL_CYCLES    = 200;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 13;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int fail_count;
    int pending_count;
    int found_count;
    int miss_count;

    // Handshake between the stimulus and the receiver process for the long hold-off.
    int holdoff_req  = 0;
    int holdoff_done = 0;

    bit sender_burst  = 1'b0;
    int primes_sent   = 0;
    int settings_used = 1;

    prime_quadratic_form_split dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    pqfs_split_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .found_count   (found_count),
        .miss_count    (miss_count)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    // Watchdog: a hung handshake or a search that never ends stops the run here.
    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles with %0d results outstanding",
                         cycles, pending_count);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Idle length shared by both sides: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    // A random prime candidate whose search stays short for the given field_d.
    function automatic logic [S_TDATA_W-1:0] pick_prime(input logic [D_W-1:0] d);
        logic [S_TDATA_W-1:0] k;
        int roll;
        roll = $urandom_range(0, 99);
        if (d == 0) begin
            // With d = 0 only a perfect square ends the search early.
            k = (roll < 50) ? $urandom_range(0, 255) : $urandom_range(0, 65535);
            return k * k;
        end
        if (roll < 60) return $urandom_range(0, 2047);
        if (roll < 85) begin
            // d + k*k hits at b = 1 in form_mode 0 and by b = 2 in form_mode 1.
            k = $urandom_range(0, 65535);
            return k * k + d;
        end
        // Noise: arbitrary medium values, kept smaller when d is small.
        return (d < 16) ? $urandom_range(0, 8191) : $urandom_range(0, 65535);
    endfunction

    // Offers one prime on the s_ channel and returns at the edge it is accepted.
    // s_tvalid is left high so that a back-to-back beat needs no second assignment.
    task automatic send_prime(input logic [S_TDATA_W-1:0] p);
        int gap;
        gap = sender_burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        primes_sent++;
    endtask

    // Stops offering and waits until every expected result has come out.
    // The first edge lets the checker's count take in the last accepted beat.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    // Writes both registers on back-to-back cycles, only once the block is idle.
    task automatic set_config(input logic [D_W-1:0] d, input logic mode);
        drain_block();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FIELD_D;
        cfg_wdata <= d;
        @(posedge aclk);
        cfg_index <= CFG_FORM_MODE;
        cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, mode};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Receiver: random ready runs and gaps, with a long hold-off on request.
    // The hold-off is counted here so that the sender keeps offering meanwhile
    // and the block backs up until s_tready drops. A ready run ends early once
    // a hold-off is requested.
    initial begin
        int run;
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (holdoff_req != holdoff_done) begin
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
                holdoff_done = holdoff_done + 1;
            end else begin
                // Now and then a long stretch with the receiver always ready.
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 500)
                                                  : $urandom_range(1, 40);
                m_tready <= 1'b1;
                for (int c = 0; c < run && holdoff_req == holdoff_done; c++) begin
                    @(posedge aclk);
                end
                gap = pick_gap();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        logic [D_W-1:0] phase_d;
        logic           phase_mode;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, first with the reset values field_d = 1, form_mode = 0.
        // Zero and one: the remainder is negative at once, or exactly zero.
        send_prime(32'd0);
        send_prime(32'd1);
        send_prime(32'd2);
        send_prime(32'd3);
        send_prime(32'd5);
        send_prime(32'd13);
        send_prime(32'hFFFE0002);          // 65535^2 + 1, largest a in form_mode 0

        // Largest squarefree d of interest, form_mode 0.
        set_config(8'd163, 1'b0);
        send_prime(32'd41);                // remainder negative on the first step
        send_prime(32'd164);
        send_prime(32'd652);
        send_prime(32'hFFFE00A4);          // 65535^2 + 163

        // form_mode 1 where sqrt(R) <= b, so the coordinate a goes negative or to zero.
        set_config(8'd2, 1'b1);
        send_prime(32'd2);
        send_prime(32'd3);

        // form_mode 1 with an odd sqrt(R) - b: the halving truncates toward zero.
        set_config(8'd4, 1'b1);
        send_prime(32'd9);

        // d = 0 keeps the remainder fixed; only squares are sent.
        set_config(8'd0, 1'b0);
        send_prime(32'd0);
        send_prime(32'd49);
        send_prime(32'hFFFE0001);
        set_config(8'd0, 1'b1);
        send_prime(32'h40000000);
        send_prime(32'hFFFE0001);

        set_config(8'd163, 1'b1);
        send_prime(32'hFFFF0029);          // 4p - 163 = 131071^2
        send_prime(32'd41);

        // Widest d the register holds.
        set_config(8'd255, 1'b1);
        send_prime(32'hFFFE0100);
        send_prime(32'd1);

        // Random part: one register setting per phase, extremes first.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin phase_d = 8'd1;   phase_mode = 1'b1; end
                1: begin phase_d = 8'd255; phase_mode = 1'b0; end
                2: begin phase_d = 8'd0;   phase_mode = 1'b1; end
                3: begin phase_d = 8'd163; phase_mode = 1'b1; end
                default: begin
                    phase_d    = D_W'($urandom_range(1, 255));
                    phase_mode = (ph == RANDOM_PHASES - 1);
                end
            endcase
            set_config(phase_d, phase_mode);
            // The receiver holds off during the second phase while beats keep coming.
            if (ph == 1) holdoff_req <= holdoff_req + 1;
            sender_burst = (ph == 3);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_prime(pick_prime(phase_d));
            end
        end
        sender_burst = 1'b0;

        drain_block();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d primes under %0d register settings, field_d 0 to 255, both form modes.",
                 primes_sent, settings_used);
        $display("Results checked: %0d splits found, %0d searches ended without one.",
                 found_count, miss_count);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
